>>> design/hpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared types and constants of the homogeneous point transform.
// ----------------------------------------------------------------------------
package hpt_pkg;

  localparam int COORD_W       = 32;
  localparam int PROD_W        = 2 * COORD_W;
  localparam int FRAC_BITS_DEF = 16;
  localparam int FRAC_MIN      = 8;
  localparam int RSUM_W        = PROD_W + 3 - FRAC_MIN;
  localparam int QUO_W         = COORD_W + 1;
  localparam int NUM_PAIRS     = 8;
  localparam int PAIR_IDX_W    = 3;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 64;
  localparam int MID_DEPTH     = 4;
  localparam int OUT_DEPTH     = 2;

  localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [RSUM_W-1:0]  rsum_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
  } in_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    logic   saturated;
  } out_t;

  typedef struct packed {
    rsum_t [2:0] row;
    rsum_t       w;
  } mid_t;

endpackage
`default_nettype wire

>>> design/hpt_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_fifo
// Small register queue with first-word fall-through read.
// ----------------------------------------------------------------------------
module hpt_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wr_data,
  input  wire logic         pop,
  output logic      [W-1:0] rd_data,
  output logic              full,
  output logic              empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> design/hpt_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_front
// Matrix registers, input capture, products and the four row sums.
// ----------------------------------------------------------------------------
module hpt_front #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [hpt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [hpt_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               in_push,
  input  wire hpt_pkg::in_t                       in_data,
  output logic                                    in_full,
  output logic                                    mid_push,
  output hpt_pkg::mid_t                           mid_data,
  input  wire logic                               mid_full
);

  localparam int SUM_W = hpt_pkg::PROD_W + 2;

  logic [hpt_pkg::CFG_DATA_W-1:0] coef_r [hpt_pkg::NUM_PAIRS];
  hpt_pkg::coord_t                coef [16];
  hpt_pkg::coord_t                pt_r [3];
  logic signed [hpt_pkg::PROD_W-1:0] prod_r [4][3];
  hpt_pkg::coord_t                tr_r [4];
  hpt_pkg::rsum_t                 rsum_r [4];
  logic                           va_r;
  logic                           vb_r;
  logic                           vc_r;
  logic                           en;

  assign en       = !(vc_r && mid_full);
  assign in_full  = !en;
  assign mid_push = vc_r && en;

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      coef[k] = hpt_pkg::coord_t'(coef_r[k / 2][32 * (k % 2) +: 32]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < hpt_pkg::NUM_PAIRS; k++) begin
        coef_r[k] <= '0;
      end
      coef_r[0] <= hpt_pkg::CFG_DATA_W'(1) << FRAC_BITS;
      coef_r[2] <= hpt_pkg::CFG_DATA_W'(1) << (32 + FRAC_BITS);
      coef_r[5] <= hpt_pkg::CFG_DATA_W'(1) << FRAC_BITS;
      coef_r[7] <= hpt_pkg::CFG_DATA_W'(1) << (32 + FRAC_BITS);
    end else if (cfg_we && (cfg_index < hpt_pkg::CFG_IDX_W'(hpt_pkg::NUM_PAIRS))) begin
      coef_r[cfg_index[hpt_pkg::PAIR_IDX_W-1:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= in_push;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [SUM_W-1:0] s;
    if (en) begin
      pt_r[0] <= in_data.point_x;
      pt_r[1] <= in_data.point_y;
      pt_r[2] <= in_data.point_z;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r][c] <= coef[4 * r + c] * pt_r[c];
        end
        tr_r[r] <= coef[4 * r + 3];
      end
      for (int r = 0; r < 4; r++) begin
        s = SUM_W'(prod_r[r][0]) + SUM_W'(prod_r[r][1]) + SUM_W'(prod_r[r][2]);
        s = s >>> FRAC_BITS;
        rsum_r[r] <= hpt_pkg::RSUM_W'(s) + hpt_pkg::RSUM_W'(tr_r[r]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      mid_data.row[r] = rsum_r[r];
    end
    mid_data.w = rsum_r[3];
  end

endmodule
`default_nettype wire

>>> design/hpt_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_div
// Pipelined restoring divider: floor(n * 2^FRAC_BITS / m), one quotient bit
// per stage, with an overflow flag for quotients wider than QUO_W bits.
// ----------------------------------------------------------------------------
module hpt_div #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [hpt_pkg::RSUM_W-1:0]    num,
  input  wire logic [hpt_pkg::RSUM_W-1:0]    den,
  output logic      [hpt_pkg::QUO_W-1:0]     quo,
  output logic                               ovf
);

  localparam int NW  = hpt_pkg::RSUM_W;
  localparam int QB  = hpt_pkg::QUO_W;
  localparam int DW  = NW + FRAC_BITS;
  localparam int RMW = NW + 1;

  logic [RMW-1:0] rem_r [QB+1];
  logic [QB-1:0]  quo_r [QB+1];
  logic [NW-1:0]  num_r [QB+1];
  logic [NW-1:0]  den_r [QB+1];
  logic           ovf_r [QB+1];
  logic [DW-1:0]  dvd;
  logic [RMW-1:0] dvd_hi;

  assign dvd    = {num, {FRAC_BITS{1'b0}}};
  assign dvd_hi = RMW'(dvd[DW-1:QB]);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= dvd_hi;
      quo_r[0] <= '0;
      num_r[0] <= num;
      den_r[0] <= den;
      ovf_r[0] <= (dvd_hi >= RMW'(den));
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    localparam int J = QB - k;
    logic           dbit;
    logic [RMW-1:0] t;
    logic           ge;

    if (J >= FRAC_BITS) begin : g_bit
      assign dbit = num_r[k-1][J-FRAC_BITS];
    end else begin : g_zero
      assign dbit = 1'b0;
    end

    assign t  = {rem_r[k-1][RMW-2:0], dbit};
    assign ge = (t >= RMW'(den_r[k-1]));

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? t - RMW'(den_r[k-1]) : t;
        quo_r[k] <= {quo_r[k-1][QB-2:0], ge};
        num_r[k] <= num_r[k-1];
        den_r[k] <= den_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  assign quo = quo_r[QB];
  assign ovf = ovf_r[QB];

endmodule
`default_nettype wire

>>> design/hpt_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_back
// Perspective divide of the three row sums by w, bypass for w of zero or
// one, and saturation to the coordinate range.
// ----------------------------------------------------------------------------
module hpt_back #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire hpt_pkg::mid_t mid_data,
  input  wire logic          mid_empty,
  output logic               mid_pop,
  output logic               out_push,
  output hpt_pkg::out_t      out_data,
  input  wire logic          out_full
);

  localparam int NW = hpt_pkg::RSUM_W;
  localparam int CW = hpt_pkg::COORD_W;
  localparam int QB = hpt_pkg::QUO_W;
  localparam logic [NW-1:0] W_ONE = NW'(1) << FRAC_BITS;

  typedef struct packed {
    logic          neg;
    logic [CW-1:0] byp_val;
    logic          byp_sat;
  } side_t;

  logic              v_r     [QB+1];
  logic              nodiv_r [QB+1];
  side_t [2:0]       side_r  [QB+1];
  logic              en;
  logic              nodiv;
  logic [NW-1:0]     m_in;
  logic [NW-1:0]     n_in    [3];
  side_t [2:0]       side_in;
  logic [QB-1:0]     quo     [3];
  logic              ovf     [3];
  logic [CW-1:0]     res     [3];
  logic [2:0]        res_sat;

  assign en       = !(v_r[QB] && out_full);
  assign mid_pop  = en && !mid_empty;
  assign out_push = v_r[QB] && en;

  assign nodiv = (mid_data.w == '0) || ($unsigned(mid_data.w) == W_ONE);
  assign m_in  = mid_data.w[NW-1] ? NW'(-mid_data.w) : NW'(mid_data.w);

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      n_in[l] = mid_data.row[l][NW-1] ? NW'(-mid_data.row[l]) : NW'(mid_data.row[l]);
      side_in[l].neg = mid_data.row[l][NW-1] != mid_data.w[NW-1];
      if ((mid_data.row[l][NW-1:CW-1] == '0) || (mid_data.row[l][NW-1:CW-1] == '1)) begin
        side_in[l].byp_val = mid_data.row[l][CW-1:0];
        side_in[l].byp_sat = 1'b0;
      end else begin
        side_in[l].byp_val = mid_data.row[l][NW-1] ? hpt_pkg::COORD_MIN : hpt_pkg::COORD_MAX;
        side_in[l].byp_sat = 1'b1;
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    hpt_div #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk (clk),
      .en  (en),
      .num (n_in[l]),
      .den (m_in),
      .quo (quo[l]),
      .ovf (ovf[l])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QB; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= mid_pop;
      for (int k = 1; k <= QB; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nodiv_r[0] <= nodiv;
      side_r[0]  <= side_in;
      for (int k = 1; k <= QB; k++) begin
        nodiv_r[k] <= nodiv_r[k-1];
        side_r[k]  <= side_r[k-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (nodiv_r[QB]) begin
        res[l]     = side_r[QB][l].byp_val;
        res_sat[l] = side_r[QB][l].byp_sat;
      end else if (ovf[l]) begin
        res[l]     = side_r[QB][l].neg ? hpt_pkg::COORD_MIN : hpt_pkg::COORD_MAX;
        res_sat[l] = 1'b1;
      end else if (side_r[QB][l].neg) begin
        if (quo[l] > QB'(hpt_pkg::COORD_MIN)) begin
          res[l]     = hpt_pkg::COORD_MIN;
          res_sat[l] = 1'b1;
        end else begin
          res[l]     = CW'(-quo[l]);
          res_sat[l] = 1'b0;
        end
      end else if (quo[l] > QB'(hpt_pkg::COORD_MAX)) begin
        res[l]     = hpt_pkg::COORD_MAX;
        res_sat[l] = 1'b1;
      end else begin
        res[l]     = quo[l][CW-1:0];
        res_sat[l] = 1'b0;
      end
    end
    out_data.out_x     = res[0];
    out_data.out_y     = res[1];
    out_data.out_z     = res[2];
    out_data.saturated = |res_sat;
  end

endmodule
`default_nettype wire

>>> design/homogeneous_point_transform.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// homogeneous_point_transform
// 4x4 homogeneous transform of Q-format 3D points with perspective divide.
//
// Points enter through a queue-style port: a transfer happens on a clock edge
// with in_push high and in_full low. Results leave the same way: out_data is
// valid while out_empty is low and a transfer happens when out_pop is high.
// The matrix is loaded through the cfg port, one 64-bit register holding two
// coefficients per transfer (cfg_ready is always high); indexes past the
// last register are ignored. Load it only while no point is in flight.
// One point is taken per cycle while in_full is low. On its way to the output
// a point passes three front stages (capture, twelve multipliers, row sums),
// the decoupling queue, a 34-stage pipelined divider (an overflow check, then
// one quotient bit per stage) and then the result queue.
// When the receiver stops popping, the result queue fills, the divider
// pipeline holds, the middle queue fills and in_full rises; nothing is lost.
// Synchronous reset empties all queues and loads the identity matrix.
// ----------------------------------------------------------------------------
module homogeneous_point_transform #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  input  wire hpt_pkg::in_t                   in_data,
  output logic                                in_full,
  input  wire logic                           out_pop,
  output hpt_pkg::out_t                       out_data,
  output logic                                out_empty,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [hpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hpt_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic          mid_push;
  logic          mid_pop;
  logic          mid_full;
  logic          mid_empty;
  hpt_pkg::mid_t mid_wr;
  hpt_pkg::mid_t mid_rd;
  logic          res_push;
  logic          res_full;
  hpt_pkg::out_t res_wr;

  assign cfg_ready = 1'b1;

  hpt_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .mid_push  (mid_push),
    .mid_data  (mid_wr),
    .mid_full  (mid_full)
  );

  hpt_fifo #(
    .W     ($bits(hpt_pkg::mid_t)),
    .DEPTH (hpt_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (mid_push),
    .wr_data (mid_wr),
    .pop     (mid_pop),
    .rd_data (mid_rd),
    .full    (mid_full),
    .empty   (mid_empty)
  );

  hpt_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_data  (mid_rd),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .out_push  (res_push),
    .out_data  (res_wr),
    .out_full  (res_full)
  );

  hpt_fifo #(
    .W     ($bits(hpt_pkg::out_t)),
    .DEPTH (hpt_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_wr),
    .pop     (out_pop && !out_empty),
    .rd_data (out_data),
    .full    (res_full),
    .empty   (out_empty)
  );

endmodule
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the homogeneous point transform.
//
// Loads several matrices through the cfg port, streams directed and random
// points under varying push and pop pressure, and compares every result
// against a bit-exact model of the row sums, divide and saturation.
// ----------------------------------------------------------------------------
module tb;

  localparam int FB = 16;
  localparam int LATENCY = 39;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  hpt_pkg::in_t in_data = '0;
  logic in_full;
  logic out_pop = 1'b0;
  hpt_pkg::out_t out_data;
  logic out_empty;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [hpt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [hpt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic [63:0] matrix_pairs [hpt_pkg::NUM_PAIRS];
  hpt_pkg::out_t expected_points [$];
  int errors = 0;
  int checked = 0;
  int points_sent = 0;
  int sat_seen = 0;
  int push_idle_pct = 0;
  int pop_stall_pct = 0;

  typedef struct {
    hpt_pkg::in_t point;
    logic check_lit;
    hpt_pkg::out_t lit;
  } stim_row_t;

  always #10 clk = ~clk;

  homogeneous_point_transform dut (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_data(in_data),
    .in_full(in_full), .out_pop(out_pop), .out_data(out_data),
    .out_empty(out_empty), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic longint entry(int k);
    logic [63:0] p;
    p = matrix_pairs[k / 2];
    return (k % 2) ? longint'($signed(p[63:32])) : longint'($signed(p[31:0]));
  endfunction

  function automatic longint floor_frac(longint v);
    return v >>> FB;
  endfunction

  function automatic longint row_total(int r, longint x, longint y, longint z);
    longint p0, p1, p2, hi, lo, h;
    p0 = entry(4 * r) * x;
    p1 = entry(4 * r + 1) * y;
    p2 = entry(4 * r + 2) * z;
    h = floor_frac(p0); hi = h; lo = p0 - (h <<< FB);
    h = floor_frac(p1); hi += h; lo += p1 - (h <<< FB);
    h = floor_frac(p2); hi += h; lo += p2 - (h <<< FB);
    return hi + floor_frac(lo) + entry(4 * r + 3);
  endfunction

  function automatic hpt_pkg::coord_t clamp32(longint v, inout logic flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return hpt_pkg::COORD_MAX;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return hpt_pkg::COORD_MIN;
    end
    return hpt_pkg::coord_t'(v);
  endfunction

  function automatic hpt_pkg::coord_t divide_clamp(longint num, longint den,
                                                   inout logic flag);
    logic neg;
    logic [63:0] n, m, q1, rem, frac, mag;
    neg = (num < 0) != (den < 0);
    n = num < 0 ? -num : num;
    m = den < 0 ? -den : den;
    q1 = n / m;
    rem = n % m;
    frac = 0;
    for (int i = 0; i < FB; i++) begin
      rem = rem << 1;
      frac = frac << 1;
      if (rem >= m) begin
        rem -= m;
        frac |= 1;
      end
    end
    if (q1 >= (64'd1 << 40)) begin
      flag = 1'b1;
      return neg ? hpt_pkg::COORD_MIN : hpt_pkg::COORD_MAX;
    end
    mag = (q1 << FB) | frac;
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        flag = 1'b1;
        return hpt_pkg::COORD_MIN;
      end
      return hpt_pkg::coord_t'(-mag);
    end
    if (mag > 64'h7FFF_FFFF) begin
      flag = 1'b1;
      return hpt_pkg::COORD_MAX;
    end
    return hpt_pkg::coord_t'(mag);
  endfunction

  function automatic hpt_pkg::out_t transform_point(hpt_pkg::in_t p);
    hpt_pkg::out_t o;
    longint x, y, z, w, s[3];
    logic flag;
    hpt_pkg::coord_t c[3];
    x = p.point_x;
    y = p.point_y;
    z = p.point_z;
    flag = 1'b0;
    w = row_total(3, x, y, z);
    for (int r = 0; r < 3; r++) begin
      s[r] = row_total(r, x, y, z);
      if (w == 0 || w == (longint'(1) <<< FB)) c[r] = clamp32(s[r], flag);
      else c[r] = divide_clamp(s[r], w, flag);
    end
    o.out_x = c[0];
    o.out_y = c[1];
    o.out_z = c[2];
    o.saturated = flag;
    return o;
  endfunction

  function automatic hpt_pkg::coord_t random_coord();
    case ($urandom_range(0, 7))
      0: return hpt_pkg::COORD_MAX;
      1: return hpt_pkg::COORD_MIN;
      2: return hpt_pkg::coord_t'($urandom_range(0, 2 ** 20)) - hpt_pkg::coord_t'(2 ** 19);
      3: return hpt_pkg::coord_t'(longint'($urandom_range(0, 64)) - 32) <<< FB;
      default: return hpt_pkg::coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] random_coef();
    case ($urandom_range(0, 6))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'd0;
      3: return 32'h0001_0000;
      4: return $urandom_range(0, 2 ** 18) - 2 ** 17;
      default: return $urandom;
    endcase
  endfunction

  task automatic write_pair(int idx, logic [63:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx[hpt_pkg::CFG_IDX_W-1:0];
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx < hpt_pkg::NUM_PAIRS) matrix_pairs[idx] = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_point(hpt_pkg::in_t p);
    while ($urandom_range(0, 99) < push_idle_pct) begin
      @(negedge clk);
      in_push <= 1'b0;
    end
    @(negedge clk);
    in_push <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (in_full);
    expected_points.push_back(transform_point(p));
    points_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_push <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  always @(negedge clk) out_pop <= ($urandom_range(0, 99) >= pop_stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        hpt_pkg::out_t e;
        e = expected_points.pop_front();
        checked++;
        if (out_data.saturated) sat_seen++;
        if (out_data.out_x !== e.out_x)
          $display("%0t: out_x expected %h actual %h", $time, e.out_x, out_data.out_x);
        if (out_data.out_y !== e.out_y)
          $display("%0t: out_y expected %h actual %h", $time, e.out_y, out_data.out_y);
        if (out_data.out_z !== e.out_z)
          $display("%0t: out_z expected %h actual %h", $time, e.out_z, out_data.out_z);
        if (out_data.saturated !== e.saturated)
          $display("%0t: saturated expected %b actual %b", $time, e.saturated,
                   out_data.saturated);
        if (out_data !== e) errors++;
      end
    end
  end

  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    hpt_pkg::in_t p;
    int idle_modes [4][2];
    idle_modes = '{'{0, 0}, '{82, 0}, '{0, 82}, '{7, 7}};
    for (int i = 0; i < hpt_pkg::NUM_PAIRS; i++) matrix_pairs[i] = 64'd0;
    matrix_pairs[0] = 64'd1 << FB;
    matrix_pairs[2] = 64'd1 << (32 + FB);
    matrix_pairs[5] = 64'd1 << FB;
    matrix_pairs[7] = 64'd1 << (32 + FB);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Identity after reset: points pass straight through.
    row.check_lit = 1'b1;
    row.point = '{hpt_pkg::COORD_MAX, hpt_pkg::COORD_MIN, 32'sd0};
    row.lit = '{hpt_pkg::COORD_MAX, hpt_pkg::COORD_MIN, 32'sd0, 1'b0};
    rows.push_back(row);
    row.point = '{32'sh0001_0000, -32'sh0002_8000, 32'sh0000_0001};
    row.lit = '{32'sh0001_0000, -32'sh0002_8000, 32'sh0000_0001, 1'b0};
    rows.push_back(row);
    row.point = '{32'shFFFF_FFFF, 32'sh7FFF_0000, hpt_pkg::COORD_MIN};
    row.lit = '{32'shFFFF_FFFF, 32'sh7FFF_0000, hpt_pkg::COORD_MIN, 1'b0};
    rows.push_back(row);
    foreach (rows[i]) begin
      send_point(rows[i].point);
      if (expected_points[$] !== rows[i].lit) begin
        $display("%0t: table row %0d expected %h model %h", $time, i,
                 rows[i].lit, expected_points[$]);
        errors++;
      end
    end
    drain();

    // Scale x by nearly 2^15 with w = 0.5: large points saturate; zero w row afterwards.
    write_pair(0, 64'h7FFF_FFFF);
    write_pair(7, {32'h0000_8000, 32'd0});
    write_pair(9, 64'hFFFF_FFFF_FFFF_FFFF);
    foreach (rows[i]) send_point(rows[i].point);
    drain();
    write_pair(7, 64'd0);
    foreach (rows[i]) send_point(rows[i].point);
    send_point('{hpt_pkg::COORD_MIN, hpt_pkg::COORD_MIN, hpt_pkg::COORD_MIN});
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      for (int k = 0; k < hpt_pkg::NUM_PAIRS; k++) begin
        logic [63:0] v;
        if (phase == 0) v = 64'hFFFF_FFFF_FFFF_FFFF;
        else if (phase == 1) v = 64'h7FFF_FFFF_7FFF_FFFF;
        else if (phase == 2) v = 64'h8000_0000_8000_0000;
        else if (phase == 3) v = 64'd0;
        else v = {random_coef(), random_coef()};
        if (phase > 3 && k == 7 && $urandom_range(0, 3) == 0)
          v = {32'h0001_0000, v[31:0]};
        write_pair(k, v);
      end
      push_idle_pct = idle_modes[phase % 4][0];
      pop_stall_pct = idle_modes[phase % 4][1];
      for (int n = 0; n < 140; n++) begin
        p.point_x = random_coord();
        p.point_y = random_coord();
        p.point_z = random_coord();
        send_point(p);
      end
      drain();
      pop_stall_pct = 0;
    end

    $display("Sent %0d points over 15 matrix settings, checked %0d results,",
             points_sent, checked);
    $display("%0d of them saturated, under four push/pop idle patterns.", sat_seen);
    if (errors == 0 && expected_points.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
